@@ rtl/sida_pkg.sv @@
`default_nettype none

package sida_pkg;

   localparam int VALUE_WIDTH       = 32;
   localparam int CHAR_WIDTH        = 6;
   localparam int DIGIT_WIDTH       = 4;
   localparam int MAX_DIGITS        = 10;
   localparam int DIGIT_INDEX_WIDTH = 4;
   localparam int PROD_WIDTH        = 2 * VALUE_WIDTH;
   localparam int QUOT_LSB          = 35;
   localparam int QUOT_WIDTH        = PROD_WIDTH - QUOT_LSB;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = 1;
   localparam int QUEUE_CNT_WIDTH   = 2;

   localparam logic [CHAR_WIDTH-1:0]  ASCII_MINUS = 6'd45;
   localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0]  ASCII_NINE  = 6'd57;
   localparam logic [VALUE_WIDTH-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam logic [DIGIT_INDEX_WIDTH-1:0] LAST_DIGIT_INDEX =
      DIGIT_INDEX_WIDTH'(MAX_DIGITS - 1);

   typedef struct packed {
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
   } work_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIGITS,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

@@ rtl/sida_req_if.sv @@
`default_nettype none

interface sida_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sida_pkg::VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/sida_rsp_if.sv @@
`default_nettype none

interface sida_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sida_pkg::CHAR_WIDTH-1:0] text_char;
   logic                            last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

@@ rtl/sida_front.sv @@
`default_nettype none

module sida_front (
   sida_req_if.sink           req,
   output logic               push_valid,
   input  logic               push_ready,
   output sida_pkg::work_type push_data
);

   logic [sida_pkg::VALUE_WIDTH-1:0] raw;

   assign raw        = req.value;
   assign push_valid = req.valid;
   assign req.ready  = push_ready;

   // unsigned negation, so the most negative word keeps its full magnitude
   always_comb begin
      push_data.negative  = raw[sida_pkg::VALUE_WIDTH-1];
      push_data.magnitude = raw[sida_pkg::VALUE_WIDTH-1] ? (~raw + 32'd1) : raw;
   end

endmodule

`default_nettype wire

@@ rtl/sida_queue.sv @@
`default_nettype none

module sida_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sida_pkg::work_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sida_pkg::work_type pop_data
);

   sida_pkg::work_type                        entry_ff [sida_pkg::QUEUE_DEPTH];
   logic [sida_pkg::QUEUE_PTR_WIDTH-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sida_pkg::QUEUE_PTR_WIDTH-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sida_pkg::QUEUE_CNT_WIDTH-1:0]      count_ff, count_in;
   logic                                      do_push, do_pop;

   assign push_ready = (count_ff != sida_pkg::QUEUE_CNT_WIDTH'(sida_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sida_back.sv @@
`default_nettype none

module sida_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  sida_pkg::work_type pop_data,
   sida_rsp_if.source         rsp
);

   sida_pkg::state_type                          state_ff, state_in;
   logic [sida_pkg::PROD_WIDTH-1:0]              prod_ff, prod_in;
   logic [sida_pkg::VALUE_WIDTH-1:0]             rem_ff, rem_in;
   logic                                         sign_ff, sign_in;
   logic [sida_pkg::DIGIT_WIDTH-1:0]             digit_ff [sida_pkg::MAX_DIGITS];
   logic [sida_pkg::DIGIT_INDEX_WIDTH-1:0]       count_ff, count_in;
   logic [sida_pkg::DIGIT_INDEX_WIDTH-1:0]       idx_ff, idx_in;
   logic [sida_pkg::QUOT_WIDTH-1:0]              quot;
   logic [sida_pkg::DIGIT_WIDTH-1:0]             quot_lo;
   logic [sida_pkg::DIGIT_WIDTH-1:0]             quot_ten_lo;
   logic [sida_pkg::DIGIT_WIDTH-1:0]             digit;
   logic [sida_pkg::VALUE_WIDTH-1:0]             mul_a;
   logic                                         digits_done;
   logic                                         rsp_take;

   // quotient by ten via reciprocal; only the low nibble is needed for the remainder
   assign quot        = prod_ff[sida_pkg::PROD_WIDTH-1:sida_pkg::QUOT_LSB];
   assign quot_lo     = quot[sida_pkg::DIGIT_WIDTH-1:0];
   assign quot_ten_lo = (quot_lo << 3) + (quot_lo << 1);
   assign digit       = rem_ff[sida_pkg::DIGIT_WIDTH-1:0] - quot_ten_lo;
   assign digits_done = (quot == '0) || (count_ff == sida_pkg::LAST_DIGIT_INDEX);
   assign rsp_take    = rsp.valid && rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            if (pop_valid) begin
               state_in = sida_pkg::ST_DIGITS;
            end
         end
         sida_pkg::ST_DIGITS: begin
            if (digits_done) begin
               state_in = sida_pkg::ST_EMIT;
            end
         end
         sida_pkg::ST_EMIT: begin
            if (rsp_take && !sign_ff && (idx_ff == '0)) begin
               state_in = sida_pkg::ST_IDLE;
            end
         end
         default: state_in = sida_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready     = 1'b0;
      rsp.valid     = 1'b0;
      rsp.text_char = sida_pkg::ASCII_ZERO + sida_pkg::CHAR_WIDTH'(digit_ff[idx_ff]);
      rsp.last_char = 1'b0;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
         end
         sida_pkg::ST_DIGITS: begin
         end
         sida_pkg::ST_EMIT: begin
            rsp.valid = 1'b1;
            if (sign_ff) begin
               rsp.text_char = sida_pkg::ASCII_MINUS;
            end else begin
               rsp.last_char = (idx_ff == '0);
            end
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      rem_in   = rem_ff;
      sign_in  = sign_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      mul_a    = {sida_pkg::VALUE_WIDTH{1'b0}};
      prod_in  = prod_ff;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            mul_a    = pop_data.magnitude;
            prod_in  = sida_pkg::PROD_WIDTH'(mul_a) *
                       sida_pkg::PROD_WIDTH'(sida_pkg::RECIP_TEN);
            rem_in   = pop_data.magnitude;
            sign_in  = pop_data.negative;
            count_in = '0;
         end
         sida_pkg::ST_DIGITS: begin
            mul_a    = sida_pkg::VALUE_WIDTH'(quot);
            prod_in  = sida_pkg::PROD_WIDTH'(mul_a) *
                       sida_pkg::PROD_WIDTH'(sida_pkg::RECIP_TEN);
            rem_in   = mul_a;
            count_in = count_ff + 1'b1;
            idx_in   = count_ff;
         end
         sida_pkg::ST_EMIT: begin
            if (rsp_take) begin
               if (sign_ff) begin
                  sign_in = 1'b0;
               end else if (idx_ff != '0) begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sida_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      sign_ff  <= sign_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      if (state_ff == sida_pkg::ST_DIGITS) begin
         digit_ff[count_ff] <= digit;
      end
   end

endmodule

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii.sv @@
// flow: an accepted word is stored in the queue; the back end takes it when idle,
// splits its magnitude into n decimal digits (n from 1 to 10) in the
// reciprocal-multiply digit loop, and the character emitter then sends a '-' if
// negative and the digits, most significant first; one word is converted at a time
// a two-word queue lets new input words be taken while a conversion runs
// reset: synchronous, clears the queue and returns the converter to idle
`default_nettype none

module signed_int_to_decimal_ascii (
   input  logic       clock,
   input  logic       reset,
   sida_req_if.sink   req,
   sida_rsp_if.source rsp
);

   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;
   sida_pkg::work_type push_data, pop_data;

   sida_front u_front (
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sida_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   sida_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp)
   );

   // the final digit of a number is never followed straight away by another character
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_char |=> !rsp.valid)
      else $error("character emitted right after the last digit");

   // the sign never closes a number
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.text_char == sida_pkg::ASCII_MINUS) |-> !rsp.last_char)
      else $error("minus sign flagged as last character");

   // only a sign or a decimal digit leaves the block
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.text_char == sida_pkg::ASCII_MINUS) ||
                    ((rsp.text_char >= sida_pkg::ASCII_ZERO) &&
                     (rsp.text_char <= sida_pkg::ASCII_NINE)))
      else $error("character outside the decimal set");

endmodule

`default_nettype wire

@@ bench/signed_int_to_decimal_ascii_tb.sv @@
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

   localparam logic [sida_pkg::VALUE_WIDTH-1:0] RADIX = 32'd10;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [sida_pkg::CHAR_WIDTH-1:0] text_char;
      logic                            last_char;
   } text_char_type;

   logic clock = 1'b0;
   logic reset;

   sida_req_if req_if ();
   sida_rsp_if rsp_if ();

   signed_int_to_decimal_ascii dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   text_char_type expected_text[$];
   text_char_type oldest_char;
   int            error_count    = 0;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // decimal text of one word, sign first, most significant digit next
   function automatic void predict_text(input logic [sida_pkg::VALUE_WIDTH-1:0] raw);
      logic [sida_pkg::VALUE_WIDTH-1:0] magnitude;
      logic [sida_pkg::DIGIT_WIDTH-1:0] digits [sida_pkg::MAX_DIGITS];
      int                               n;
      text_char_type                    ch;
      magnitude = raw[sida_pkg::VALUE_WIDTH-1] ?
                  (sida_pkg::VALUE_WIDTH'(0) - raw) : raw;
      n = 0;
      do begin
         digits[n] = sida_pkg::DIGIT_WIDTH'(magnitude % RADIX);
         magnitude = magnitude / RADIX;
         n++;
      end while (magnitude != 0 && n < sida_pkg::MAX_DIGITS);
      if (raw[sida_pkg::VALUE_WIDTH-1]) begin
         ch.text_char = sida_pkg::ASCII_MINUS;
         ch.last_char = 1'b0;
         expected_text.push_back(ch);
      end
      for (int i = n - 1; i >= 0; i--) begin
         ch.text_char = sida_pkg::ASCII_ZERO + sida_pkg::CHAR_WIDTH'(digits[i]);
         ch.last_char = (i == 0);
         expected_text.push_back(ch);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_text.size() == 0) begin
               $display("%0t: character with no word pending: expected none, actual %0d last %0b",
                        $time, rsp_if.text_char, rsp_if.last_char);
               error_count++;
            end else begin
               oldest_char = expected_text.pop_front();
               if (rsp_if.text_char !== oldest_char.text_char) begin
                  $display("%0t: text_char mismatch: expected %0d, actual %0d",
                           $time, oldest_char.text_char, rsp_if.text_char);
                  error_count++;
               end
               if (rsp_if.last_char !== oldest_char.last_char) begin
                  $display("%0t: last_char mismatch: expected %0b, actual %0b",
                           $time, oldest_char.last_char, rsp_if.last_char);
                  error_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_word(input logic [sida_pkg::VALUE_WIDTH-1:0] word_value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid <= 1'b1;
      req_if.value <= word_value;
      do @(posedge clock); while (!req_if.ready);
      predict_text(word_value);
   endtask

   task automatic drain_text();
      req_if.valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly uniform over digit counts so short and long texts both appear often
   task automatic convert_random_words(input int count);
      logic [sida_pkg::VALUE_WIDTH-1:0] word_value;
      longint                           low;
      longint                           high;
      int                               n;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(3) == 0) begin
            word_value = $urandom;
         end else begin
            n = $urandom_range(sida_pkg::MAX_DIGITS, 1);
            low = 1;
            for (int j = 1; j < n; j++) low = low * 10;
            high = low * 10 - 1;
            if (n == 1) low = 0;
            if (high > 64'sd2147483647) high = 64'sd2147483647;
            word_value = sida_pkg::VALUE_WIDTH'(low + longint'($urandom_range(32'(high - low))));
            if ($urandom_range(1)) word_value = sida_pkg::VALUE_WIDTH'(0) - word_value;
         end
         send_word(word_value);
      end
      drain_text();
   endtask

   task automatic test_directed_values();
      logic signed [sida_pkg::VALUE_WIDTH-1:0] directed [22] = '{
         0, 1, -1, 9, -9, 10, -10, 99, -100, 12345, -54321,
         999999999, -999999999, 1000000000, -1000000000,
         2147483647, -2147483647, 32'sh8000_0000,
         32'sh5555_5555, 32'shAAAA_AAAA, 2000000009, -1234567890
      };
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (directed[i]) send_word(directed[i]);
      drain_text();
   endtask

   task automatic test_random_no_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      convert_random_words(90);
   endtask

   task automatic test_random_sender_idle();
      send_idle_pct  = 87;
      recv_stall_pct = 0;
      convert_random_words(90);
   endtask

   task automatic test_random_receiver_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 87;
      convert_random_words(90);
   endtask

   task automatic test_random_both_idle();
      send_idle_pct  = 21;
      recv_stall_pct = 21;
      convert_random_words(90);
   endtask

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_values();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout with %0d characters outstanding", $time, expected_text.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/sida_pkg.sv
rtl/sida_req_if.sv
rtl/sida_rsp_if.sv
rtl/sida_front.sv
rtl/sida_queue.sv
rtl/sida_back.sv
rtl/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_tb.sv
